// ===== hdl/fault_drive_cycle_aging_table_core_macros.svh =====
// Assertion macros used by the fault aging table core RTL.
`ifndef FAULT_DRIVE_CYCLE_AGING_TABLE_CORE_MACROS_SVH
`define FAULT_DRIVE_CYCLE_AGING_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define FDCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdca assertion failed");
// next-cycle implication, disabled during reset
`define FDCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdca assertion failed");
`else
`define FDCA_ASSERT_NOW(label, ante, cons)
`define FDCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/fdca_pkg.sv =====
// Types and constants for the fault drive-cycle aging table.
package fdca_pkg;

    localparam logic [7:0] DRIVE_CAP  = 8'd10;
    localparam logic [6:0] WARMUP_CAP = 7'd100;
    localparam logic [7:0] RELOAD_RST = 8'd40;

    typedef enum logic [2:0] {
        REQ_THRESH_UP   = 3'd0,
        REQ_CYCLE_END   = 3'd1,
        REQ_RESET_REC   = 3'd2,
        REQ_WARMUP      = 3'd3,
        REQ_LOAD_WARMUP = 3'd4,
        REQ_CLR_WARMUP  = 3'd5
    } req_code_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] fault_index;
        logic [7:0] confirm_cycles;
        logic [7:0] heal_cycles;
        logic       cycle_qualified;
        logic       warmup_done;
    } item_t;

    typedef struct packed {
        logic [7:0] drive_count;
        logic       present_flag;
        logic       confirmed_flag;
        logic [6:0] warmup_count;
    } rec_t;

endpackage

// ===== hdl/fdca_req_if.sv =====
// Event channel: valid/ready handshake with the event payload.
interface fdca_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [3:0] fault_index;
    logic [7:0] confirm_cycles;
    logic [7:0] heal_cycles;
    logic       cycle_qualified;
    logic       warmup_done;

    modport source (
        output valid, req_type, fault_index, confirm_cycles, heal_cycles,
               cycle_qualified, warmup_done,
        input  ready
    );
    modport sink (
        input  valid, req_type, fault_index, confirm_cycles, heal_cycles,
               cycle_qualified, warmup_done,
        output ready
    );
endinterface

// ===== hdl/fdca_rsp_if.sv =====
// Result channel: valid/ready handshake with the updated record.
interface fdca_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_count;
    logic       present_flag;
    logic       confirmed_flag;
    logic [6:0] warmup_count;

    modport source (
        output valid, drive_count, present_flag, confirmed_flag, warmup_count,
        input  ready
    );
    modport sink (
        input  valid, drive_count, present_flag, confirmed_flag, warmup_count,
        output ready
    );
endinterface

// ===== hdl/fdca_rec_update.sv =====
// Next-value logic for one fault record given one event.
module fdca_rec_update (
    input  fdca_pkg::rec_t  cur,
    input  fdca_pkg::item_t item,
    input  logic [7:0]      reload,
    output fdca_pkg::rec_t  nxt
);

    logic [7:0] ctr_inc;
    logic [7:0] ctr_dec;
    logic [6:0] wuc_dec;
    logic [6:0] wuc_load;

    always_comb
    begin
        ctr_inc  = (cur.drive_count < item.confirm_cycles) ? cur.drive_count + 8'd1
                                                           : cur.drive_count;
        ctr_dec  = cur.drive_count - 8'd1;
        if (ctr_dec > fdca_pkg::DRIVE_CAP)
        begin
            ctr_dec = fdca_pkg::DRIVE_CAP;
        end
        wuc_dec  = cur.warmup_count - 7'd1;
        if (wuc_dec > fdca_pkg::WARMUP_CAP)
        begin
            wuc_dec = fdca_pkg::WARMUP_CAP;
        end
        wuc_load = (reload > 8'(fdca_pkg::WARMUP_CAP)) ? fdca_pkg::WARMUP_CAP : reload[6:0];

        nxt = cur;
        unique case (item.req_type)
            fdca_pkg::REQ_THRESH_UP:
            begin
                if (!cur.present_flag)
                begin
                    nxt.present_flag = 1'b1;
                    if (cur.confirmed_flag)
                    begin
                        nxt.drive_count = item.heal_cycles;
                    end
                    else if (ctr_inc >= item.confirm_cycles)
                    begin
                        nxt.drive_count    = item.heal_cycles;
                        nxt.confirmed_flag = 1'b1;
                    end
                    else
                    begin
                        nxt.drive_count = ctr_inc;
                    end
                end
            end
            fdca_pkg::REQ_CYCLE_END:
            begin
                if (!cur.present_flag && item.cycle_qualified)
                begin
                    if (!cur.confirmed_flag)
                    begin
                        nxt.drive_count = '0;
                    end
                    else if (cur.drive_count != 8'd0)
                    begin
                        nxt.drive_count = ctr_dec;
                    end
                end
                // healed out once the warm-up budget is spent
                if (cur.warmup_count == 7'd0 && !cur.present_flag)
                begin
                    nxt.confirmed_flag = 1'b0;
                end
                nxt.present_flag = 1'b0;
            end
            fdca_pkg::REQ_RESET_REC:
            begin
                nxt.drive_count    = '0;
                nxt.present_flag   = 1'b0;
                nxt.confirmed_flag = 1'b0;
            end
            fdca_pkg::REQ_WARMUP:
            begin
                if (cur.drive_count == 8'd0 && item.warmup_done && cur.warmup_count != 7'd0)
                begin
                    nxt.warmup_count = wuc_dec;
                end
            end
            fdca_pkg::REQ_LOAD_WARMUP:
            begin
                nxt.warmup_count = wuc_load;
            end
            fdca_pkg::REQ_CLR_WARMUP:
            begin
                nxt.warmup_count = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== hdl/fault_drive_cycle_aging_table_core.sv =====
// Pipeline: an accepted event is registered in stage one, then its record
// in the result stage. Throughput: one event per cycle unless rsp stalls; the
// flop table RMW is in stage one, so back-to-back events see prior updates.
// Reset (rst_n, async low): table records zero, reload register 40,
// both pipeline stages empty.
`include "fault_drive_cycle_aging_table_core_macros.svh"

module fault_drive_cycle_aging_table_core #(
    parameter int NUM_FAULTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_data,
    fdca_req_if.sink   req,
    fdca_rsp_if.source rsp
);

    localparam int TBL_AW = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;

    logic [7:0]      reload_reg;
    logic [7:0]      reload_next;
    logic            s1_vld_reg;
    logic            s1_vld_next;
    fdca_pkg::item_t s1_item_reg;
    fdca_pkg::item_t s1_item_next;
    logic            rsp_vld_reg;
    logic            rsp_vld_next;
    fdca_pkg::rec_t  rsp_rec_reg;
    fdca_pkg::rec_t  rsp_rec_next;
    fdca_pkg::rec_t  tbl_reg  [NUM_FAULTS];
    fdca_pkg::rec_t  tbl_next [NUM_FAULTS];

    fdca_pkg::item_t in_item;
    logic            rsp_free;
    logic            s1_adv;
    logic            in_acc;
    logic [8:0]      idx_ext;
    logic            in_range;
    logic [TBL_AW-1:0] tbl_idx;
    fdca_pkg::rec_t  cur_rec;
    fdca_pkg::rec_t  upd_rec;

    assign in_item.req_type        = req.req_type;
    assign in_item.fault_index     = req.fault_index;
    assign in_item.confirm_cycles  = req.confirm_cycles;
    assign in_item.heal_cycles     = req.heal_cycles;
    assign in_item.cycle_qualified = req.cycle_qualified;
    assign in_item.warmup_done     = req.warmup_done;

    assign rsp_free  = !rsp_vld_reg || rsp.ready;
    assign s1_adv    = s1_vld_reg && rsp_free;
    assign req.ready = !s1_vld_reg || rsp_free;
    assign in_acc    = req.valid && req.ready;

    assign idx_ext  = 9'(s1_item_reg.fault_index);
    assign in_range = idx_ext < 9'(NUM_FAULTS);
    assign tbl_idx  = idx_ext[TBL_AW-1:0];
    assign cur_rec  = in_range ? tbl_reg[tbl_idx] : '0;

    fdca_rec_update u_update (
        .cur    (cur_rec),
        .item   (s1_item_reg),
        .reload (reload_reg),
        .nxt    (upd_rec)
    );

    always_comb
    begin
        reload_next  = wr_en ? wr_data : reload_reg;
        s1_vld_next  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);
        s1_item_next = in_acc ? in_item : s1_item_reg;
        rsp_vld_next = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_reg);
        // out-of-range faults report an all-zero record
        rsp_rec_next = s1_adv ? (in_range ? upd_rec : '0) : rsp_rec_reg;
        for (int i = 0; i < NUM_FAULTS; i++)
        begin
            tbl_next[i] = tbl_reg[i];
        end
        if (s1_adv && in_range)
        begin
            tbl_next[tbl_idx] = upd_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg  <= fdca_pkg::RELOAD_RST;
            s1_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
            for (int i = 0; i < NUM_FAULTS; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else
        begin
            reload_reg  <= reload_next;
            s1_vld_reg  <= s1_vld_next;
            rsp_vld_reg <= rsp_vld_next;
            for (int i = 0; i < NUM_FAULTS; i++)
            begin
                tbl_reg[i] <= tbl_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        rsp_rec_reg <= rsp_rec_next;
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.drive_count    = rsp_rec_reg.drive_count;
    assign rsp.present_flag   = rsp_rec_reg.present_flag;
    assign rsp.confirmed_flag = rsp_rec_reg.confirmed_flag;
    assign rsp.warmup_count   = rsp_rec_reg.warmup_count;

    `FDCA_ASSERT_NOW(a_stall_means_busy, !req.ready, s1_vld_reg)
    `FDCA_ASSERT_NOW(a_warmup_capped, s1_adv, upd_rec.warmup_count <= fdca_pkg::WARMUP_CAP)
    `FDCA_ASSERT_NEXT(a_cycle_end_clears_present, s1_adv && in_range && s1_item_reg.req_type == fdca_pkg::REQ_CYCLE_END, rsp_vld_reg && !rsp_rec_reg.present_flag)
    `FDCA_ASSERT_NEXT(a_out_of_range_zero, s1_adv && !in_range, rsp_vld_reg && rsp_rec_reg == '0)

endmodule

// ===== verif/fdca_record_checker.sv =====
// Checker for the fault aging table: predicts each record update and compares results.
`timescale 1ns / 1ps

module fdca_record_checker
    import fdca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_data,
    fdca_req_if         req,
    fdca_rsp_if         rsp,
    output int unsigned mismatches,
    output int unsigned in_flight
);

    localparam int FAULT_COUNT = 16;
    localparam int REPORT_MAX  = 10;

    logic [7:0] drive_cnt   [FAULT_COUNT];
    logic       seen_now    [FAULT_COUNT];
    logic       confirmed   [FAULT_COUNT];
    logic [6:0] warmup_left [FAULT_COUNT];
    logic [7:0] reload_val;

    rec_t expected_records[$];

    // One read-modify-write of the addressed record; returns the record after it.
    function automatic rec_t apply_event(item_t ev);
        rec_t       upd;
        logic [7:0] cnt;
        logic       pres;
        logic       conf;
        logic [6:0] wu;
        int         idx;
        idx = ev.fault_index;
        if (idx >= FAULT_COUNT)
            return '0;
        cnt  = drive_cnt[idx];
        pres = seen_now[idx];
        conf = confirmed[idx];
        wu   = warmup_left[idx];
        case (ev.req_type)
            REQ_THRESH_UP:
                if (!pres)
                begin
                    pres = 1'b1;
                    if (conf)
                        cnt = ev.heal_cycles;
                    else
                    begin
                        if (cnt < ev.confirm_cycles)
                            cnt = cnt + 8'd1;
                        if (cnt >= ev.confirm_cycles)
                        begin
                            cnt  = ev.heal_cycles;
                            conf = 1'b1;
                        end
                    end
                end
            REQ_CYCLE_END:
            begin
                if (!pres && ev.cycle_qualified)
                begin
                    if (conf)
                    begin
                        if (cnt != 8'd0)
                            cnt = (cnt - 8'd1 < DRIVE_CAP) ? cnt - 8'd1 : DRIVE_CAP;
                    end
                    else
                        cnt = 8'd0;
                end
                // healing ends only once warm-ups are used up
                if (wu == 7'd0 && !pres)
                    conf = 1'b0;
                pres = 1'b0;
            end
            REQ_RESET_REC:
            begin
                cnt  = 8'd0;
                pres = 1'b0;
                conf = 1'b0;
            end
            REQ_WARMUP:
                if (cnt == 8'd0 && ev.warmup_done && wu != 7'd0)
                    wu = (wu - 7'd1 < WARMUP_CAP) ? wu - 7'd1 : WARMUP_CAP;
            REQ_LOAD_WARMUP:
                wu = (reload_val > {1'b0, WARMUP_CAP}) ? WARMUP_CAP : reload_val[6:0];
            REQ_CLR_WARMUP:
                wu = 7'd0;
            default:
                ;
        endcase
        drive_cnt[idx]   = cnt;
        seen_now[idx]    = pres;
        confirmed[idx]   = conf;
        warmup_left[idx] = wu;
        upd.drive_count    = cnt;
        upd.present_flag   = pres;
        upd.confirmed_flag = conf;
        upd.warmup_count   = wu;
        return upd;
    endfunction

    task automatic note_mismatch(string what, rec_t exp_rec, rec_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: expected cnt=%0d pres=%0b conf=%0b wu=%0d, got cnt=%0d pres=%0b conf=%0b wu=%0d",
                     $realtime, what, exp_rec.drive_count, exp_rec.present_flag,
                     exp_rec.confirmed_flag, exp_rec.warmup_count, got.drive_count,
                     got.present_flag, got.confirmed_flag, got.warmup_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t ev;
        rec_t  got;
        rec_t  exp_rec;
        if (!rst_n)
        begin
            for (int i = 0; i < FAULT_COUNT; i++)
            begin
                drive_cnt[i]   = 8'd0;
                seen_now[i]    = 1'b0;
                confirmed[i]   = 1'b0;
                warmup_left[i] = 7'd0;
            end
            reload_val = RELOAD_RST;
            expected_records.delete();
            mismatches = 0;
            in_flight  = 0;
        end
        else
        begin
            if (wr_en)
                reload_val = wr_data;
            if (rsp.valid && rsp.ready)
            begin
                got.drive_count    = rsp.drive_count;
                got.present_flag   = rsp.present_flag;
                got.confirmed_flag = rsp.confirmed_flag;
                got.warmup_count   = rsp.warmup_count;
                if (expected_records.size() == 0)
                    note_mismatch("unexpected result", '0, got);
                else
                begin
                    exp_rec = expected_records.pop_front();
                    if (got.drive_count !== exp_rec.drive_count
                        || got.present_flag !== exp_rec.present_flag
                        || got.confirmed_flag !== exp_rec.confirmed_flag
                        || got.warmup_count !== exp_rec.warmup_count)
                        note_mismatch("record mismatch", exp_rec, got);
                end
            end
            if (req.valid && req.ready)
            begin
                ev.req_type        = req.req_type;
                ev.fault_index     = req.fault_index;
                ev.confirm_cycles  = req.confirm_cycles;
                ev.heal_cycles     = req.heal_cycles;
                ev.cycle_qualified = req.cycle_qualified;
                ev.warmup_done     = req.warmup_done;
                expected_records.push_back(apply_event(ev));
            end
            in_flight = expected_records.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Top of the fault aging table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import fdca_pkg::*;

    localparam int          PHASE_ITEMS = 380;
    localparam int          STALL_LIMIT = 1000;
    localparam int          IDLE_PCT    = 36;
    // request codes with no defined action
    localparam logic [2:0]  REQ_SPARE_A = 3'd6;
    localparam logic [2:0]  REQ_SPARE_B = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        no_idle;
    int unsigned mismatches;
    int unsigned in_flight;
    int unsigned quiet_cycles;

    fdca_req_if req_ch ();
    fdca_rsp_if rsp_ch ();

    fault_drive_cycle_aging_table_core #(
        .NUM_FAULTS (16)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    fdca_record_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic item_t make_event(logic [2:0] code, logic [3:0] idx, logic [7:0] thr,
                                         logic [7:0] heal, logic qual, logic wdone);
        item_t ev;
        ev.req_type        = code;
        ev.fault_index     = idx;
        ev.confirm_cycles  = thr;
        ev.heal_cycles     = heal;
        ev.cycle_qualified = qual;
        ev.warmup_done     = wdone;
        return ev;
    endfunction

    // Mostly a few faults with small thresholds so records confirm, heal and age out.
    function automatic item_t random_event();
        item_t       ev;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            ev.req_type = REQ_THRESH_UP;
        else if (pick < 60)
            ev.req_type = REQ_CYCLE_END;
        else if (pick < 82)
            ev.req_type = REQ_WARMUP;
        else if (pick < 88)
            ev.req_type = REQ_LOAD_WARMUP;
        else if (pick < 92)
            ev.req_type = REQ_CLR_WARMUP;
        else if (pick < 96)
            ev.req_type = REQ_RESET_REC;
        else if (pick < 98)
            ev.req_type = REQ_SPARE_A;
        else
            ev.req_type = REQ_SPARE_B;
        ev.fault_index = ($urandom_range(99) < 70) ? 4'($urandom_range(3))
                                                   : 4'($urandom_range(15));
        ev.confirm_cycles = ($urandom_range(99) < 80) ? 8'($urandom_range(4))
                                                      : 8'($urandom_range(255));
        ev.heal_cycles = ($urandom_range(99) < 70) ? 8'($urandom_range(12))
                                                   : 8'($urandom_range(255));
        ev.cycle_qualified = ($urandom_range(99) < 80);
        ev.warmup_done     = ($urandom_range(99) < 80);
        return ev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_event(item_t ev);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= ev.req_type;
        req_ch.fault_index     <= ev.fault_index;
        req_ch.confirm_cycles  <= ev.confirm_cycles;
        req_ch.heal_cycles     <= ev.heal_cycles;
        req_ch.cycle_qualified <= ev.cycle_qualified;
        req_ch.warmup_done     <= ev.warmup_done;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Let every pending result drain, then rewrite the reload register.
    task automatic drain_and_write(logic [7:0] value);
        req_ch.valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        wr_en                  = 1'b0;
        wr_data                = 8'd0;
        no_idle                = 1'b0;
        quiet_cycles           = 0;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = REQ_THRESH_UP;
        req_ch.fault_index     = 4'd0;
        req_ch.confirm_cycles  = 8'd0;
        req_ch.heal_cycles     = 8'd0;
        req_ch.cycle_qualified = 1'b0;
        req_ch.warmup_done     = 1'b0;
        rsp_ch.ready           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: immediate confirm, heal cap, unqualified cycles, warm-up aging
        send_event(make_event(REQ_LOAD_WARMUP, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_THRESH_UP, 4'd0, 8'd0, 8'd255, 1'b1, 1'b1));
        send_event(make_event(REQ_THRESH_UP, 4'd0, 8'd0, 8'd3, 1'b1, 1'b1));
        send_event(make_event(REQ_CYCLE_END, 4'd0, 8'd0, 8'd0, 1'b1, 1'b0));
        send_event(make_event(REQ_CYCLE_END, 4'd0, 8'd0, 8'd0, 1'b1, 1'b0));
        send_event(make_event(REQ_CYCLE_END, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_WARMUP, 4'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        send_event(make_event(REQ_THRESH_UP, 4'd1, 8'd255, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_CYCLE_END, 4'd1, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_THRESH_UP, 4'd1, 8'd2, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_CYCLE_END, 4'd1, 8'd0, 8'd0, 1'b1, 1'b1));
        send_event(make_event(REQ_CYCLE_END, 4'd1, 8'd0, 8'd0, 1'b1, 1'b1));
        send_event(make_event(REQ_LOAD_WARMUP, 4'd15, 8'd255, 8'd255, 1'b1, 1'b1));
        send_event(make_event(REQ_WARMUP, 4'd15, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_WARMUP, 4'd15, 8'd0, 8'd0, 1'b0, 1'b1));
        send_event(make_event(REQ_CLR_WARMUP, 4'd15, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_WARMUP, 4'd15, 8'd0, 8'd0, 1'b1, 1'b1));
        send_event(make_event(REQ_RESET_REC, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_SPARE_A, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_SPARE_B, 4'd1, 8'd255, 8'd255, 1'b1, 1'b1));
        send_event(make_event(REQ_THRESH_UP, 4'd2, 8'd1, 8'd5, 1'b1, 1'b1));
        send_event(make_event(REQ_CYCLE_END, 4'd2, 8'd0, 8'd0, 1'b0, 1'b0));
        send_event(make_event(REQ_THRESH_UP, 4'd2, 8'd1, 8'd7, 1'b0, 1'b0));
        send_event(make_event(REQ_RESET_REC, 4'd15, 8'd0, 8'd0, 1'b0, 1'b0));

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: drain_and_write(8'd255);
                1: drain_and_write(8'd0);
                2: drain_and_write(8'd101);
                3: drain_and_write(8'd100);
                default: drain_and_write(8'($urandom_range(255)));
            endcase
            // load the new reload value into the busy records right away
            for (int f = 0; f < 4; f++)
                send_event(make_event(REQ_LOAD_WARMUP, 4'(f), 8'd0, 8'd0, 1'b0, 1'b0));
            no_idle = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_event(random_event());
            no_idle = 1'b0;
        end

        req_ch.valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fdca_pkg.sv
hdl/fdca_req_if.sv
hdl/fdca_rsp_if.sv
hdl/fdca_rec_update.sv
hdl/fault_drive_cycle_aging_table_core.sv
verif/fdca_record_checker.sv
verif/tb.sv
